### hdl/uyrc_pkg.sv
// ----------------------------------------------------------------------------
// UYVY to RGB555 crop package
// Shared payload types, register indexes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uyrc_pkg;

  localparam int unsigned CFG_W = 12;

  typedef enum logic [1:0] {
    REG_SRC_PAIRS = 2'd0,
    REG_DST_PAIRS = 2'd1,
    REG_SRC_ROWS  = 2'd2,
    REG_DST_ROWS  = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] SRC_PAIRS_RST = 12'd160;
  localparam logic [CFG_W-1:0] DST_PAIRS_RST = 12'd160;
  localparam logic [CFG_W-1:0] SRC_ROWS_RST  = 12'd240;
  localparam logic [CFG_W-1:0] DST_ROWS_RST  = 12'd240;

  typedef struct packed {
    logic [7:0] chroma_u;
    logic [7:0] luma_first;
    logic [7:0] chroma_v;
    logic [7:0] luma_second;
    logic       frame_start;
  } uyrc_in_t;

  typedef struct packed {
    logic [15:0] first_pixel;
    logic [15:0] second_pixel;
    logic        row_end;
  } uyrc_out_t;

  typedef struct packed {
    logic keep;
    logic row_end;
  } uyrc_crop_t;

endpackage

### hdl/uyrc_conv.sv
// ----------------------------------------------------------------------------
// UYVY pair color converter
// Converts one UYVY word into two RGB555 pixels with BT.601 coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uyrc_conv
  import uyrc_pkg::*;
(
  input  logic [7:0]  chroma_u_i,
  input  logic [7:0]  chroma_v_i,
  input  logic [7:0]  luma_first_i,
  input  logic [7:0]  luma_second_i,
  output logic [15:0] first_pixel_o,
  output logic [15:0] second_pixel_o
);

  localparam logic signed [19:0] K_Y    = 20'sd298;
  localparam logic signed [19:0] K_RV   = 20'sd409;
  localparam logic signed [19:0] K_GU   = 20'sd100;
  localparam logic signed [19:0] K_GV   = 20'sd208;
  localparam logic signed [19:0] K_BU   = 20'sd516;
  localparam logic signed [19:0] Y_OFS  = 20'sd16;
  localparam logic signed [19:0] C_OFS  = 20'sd128;
  localparam logic signed [19:0] ROUND  = 20'sd128;

  logic signed [19:0] d;
  logic signed [19:0] e;
  logic signed [19:0] r_term;
  logic signed [19:0] g_term;
  logic signed [19:0] b_term;

  function automatic logic [4:0] chan5(logic signed [19:0] s);
    logic [4:0] v;
    if (s[19]) begin
      v = 5'd0;
    end else if (|s[18:16]) begin
      v = 5'h1f;
    end else begin
      v = s[15:11];
    end
    return v;
  endfunction

  function automatic logic [15:0] pack_pixel(logic [7:0] y, logic signed [19:0] rk,
                                             logic signed [19:0] gk,
                                             logic signed [19:0] bk);
    logic signed [19:0] c;
    c = ($signed({12'd0, y}) - Y_OFS) * K_Y + ROUND;
    return {1'b1, chan5(c + bk), chan5(c + gk), chan5(c + rk)};
  endfunction

  always_comb begin
    d      = $signed({12'd0, chroma_u_i}) - C_OFS;
    e      = $signed({12'd0, chroma_v_i}) - C_OFS;
    r_term = K_RV * e;
    g_term = -(K_GU * d) - (K_GV * e);
    b_term = K_BU * d;
  end

  assign first_pixel_o  = pack_pixel(luma_first_i, r_term, g_term, b_term);
  assign second_pixel_o = pack_pixel(luma_second_i, r_term, g_term, b_term);

endmodule

### hdl/uyrc_crop.sv
// ----------------------------------------------------------------------------
// UYVY crop control
// Holds the size registers and the column and row counters, and decides for
// each accepted word whether it lies in the kept area.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uyrc_crop
  import uyrc_pkg::*;
#(
  parameter int unsigned MAX_PAIRS_PER_ROW = 2048,
  parameter int unsigned MAX_ROWS          = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             fire_i,
  input  logic             frame_start_i,
  output uyrc_crop_t       crop_o
);

  localparam int unsigned CW  = $clog2(MAX_PAIRS_PER_ROW);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned SWW = $clog2(MAX_PAIRS_PER_ROW + 1);
  localparam int unsigned SHW = $clog2(MAX_ROWS + 1);
  localparam int unsigned EWW = (SWW > CFG_W) ? SWW : CFG_W;
  localparam int unsigned EHW = (SHW > CFG_W) ? SHW : CFG_W;

  logic [CFG_W-1:0] src_pairs_q, dst_pairs_q, src_rows_q, dst_rows_q;
  logic [CW-1:0]    col_q, col_d, cc;
  logic [RW-1:0]    row_q, row_d, rc;
  logic             over_q, over_d, fo;
  logic [SWW-1:0]   sw, dw, kw;
  logic [SHW-1:0]   sh, dh, kh;

  function automatic logic [SWW-1:0] eff_w(logic [CFG_W-1:0] r);
    logic [EWW-1:0] ext;
    logic [SWW-1:0] v;
    ext = EWW'(r);
    if (r == '0) begin
      v = SWW'(1);
    end else if (ext > EWW'(MAX_PAIRS_PER_ROW)) begin
      v = SWW'(MAX_PAIRS_PER_ROW);
    end else begin
      v = SWW'(ext);
    end
    return v;
  endfunction

  function automatic logic [SHW-1:0] eff_h(logic [CFG_W-1:0] r);
    logic [EHW-1:0] ext;
    logic [SHW-1:0] v;
    ext = EHW'(r);
    if (r == '0) begin
      v = SHW'(1);
    end else if (ext > EHW'(MAX_ROWS)) begin
      v = SHW'(MAX_ROWS);
    end else begin
      v = SHW'(ext);
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_pairs_q <= SRC_PAIRS_RST;
      dst_pairs_q <= DST_PAIRS_RST;
      src_rows_q  <= SRC_ROWS_RST;
      dst_rows_q  <= DST_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_PAIRS: src_pairs_q <= cfg_data_i;
        REG_DST_PAIRS: dst_pairs_q <= cfg_data_i;
        REG_SRC_ROWS:  src_rows_q  <= cfg_data_i;
        REG_DST_ROWS:  dst_rows_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = eff_w(src_pairs_q);
    dw = eff_w(dst_pairs_q);
    sh = eff_h(src_rows_q);
    dh = eff_h(dst_rows_q);
    kw = (sw < dw) ? sw : dw;
    kh = (sh < dh) ? sh : dh;

    cc = frame_start_i ? '0 : col_q;
    rc = frame_start_i ? '0 : row_q;
    fo = frame_start_i ? 1'b0 : over_q;

    crop_o.keep    = !fo && (SWW'(cc) < kw) && (SHW'(rc) < kh);
    crop_o.row_end = (SWW'(cc) == kw - SWW'(1));

    col_d  = cc;
    row_d  = rc;
    over_d = fo;
    if (!fo) begin
      if (SWW'(cc) >= sw - SWW'(1)) begin
        col_d = '0;
        if (SHW'(rc) >= sh - SHW'(1)) begin
          over_d = 1'b1;
        end else begin
          row_d = rc + RW'(1);
        end
      end else begin
        col_d = cc + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      over_q <= 1'b0;
    end else if (fire_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      over_q <= over_d;
    end
  end

endmodule

### hdl/uyvy_to_rgb555_crop.sv
// ----------------------------------------------------------------------------
// UYVY to RGB555 converter with crop
// Converts UYVY 4:2:2 words to pairs of RGB555 pixels and crops the source
// frame to the smaller of the source and destination sizes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (uyrc_in_t)
//  out      output     out_valid_o / out_stall_i out_data_o (uyrc_out_t)
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word can be accepted every cycle unless the input stalls; a kept word
// passes through the input register, then the result register, to the output.
// Words outside the kept area are dropped at the input and only advance
// the counters. Reset clears the counters and loads the default sizes.
// A stall at the output holds the result register, and the input stalls
// only when the input register is full and cannot move forward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uyvy_to_rgb555_crop
  import uyrc_pkg::*;
#(
  parameter int unsigned MAX_PAIRS_PER_ROW = 2048,
  parameter int unsigned MAX_ROWS          = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uyrc_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uyrc_out_t        out_data_o
);

  logic       in_fire;
  logic       s1_adv;
  uyrc_crop_t crop;

  logic       s1_valid_q;
  uyrc_in_t   s1_data_q;
  logic       s1_row_end_q;
  logic       out_valid_q;
  uyrc_out_t  out_data_q;
  logic [15:0] first_pixel, second_pixel;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  uyrc_crop #(
    .MAX_PAIRS_PER_ROW (MAX_PAIRS_PER_ROW),
    .MAX_ROWS          (MAX_ROWS)
  ) u_crop (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (in_fire),
    .frame_start_i (in_data_i.frame_start),
    .crop_o        (crop)
  );

  uyrc_conv u_conv (
    .chroma_u_i     (s1_data_q.chroma_u),
    .chroma_v_i     (s1_data_q.chroma_v),
    .luma_first_i   (s1_data_q.luma_first),
    .luma_second_i  (s1_data_q.luma_second),
    .first_pixel_o  (first_pixel),
    .second_pixel_o (second_pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= crop.keep;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && crop.keep) begin
      s1_data_q    <= in_data_i;
      s1_row_end_q <= crop.row_end;
    end
    if (s1_adv) begin
      out_data_q.first_pixel  <= first_pixel;
      out_data_q.second_pixel <= second_pixel;
      out_data_q.row_end      <= s1_row_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the UYVY to RGB555 converter with crop
// Drives UYVY words with random gaps and output stalls. A behavioral model
// of the color conversion and of the crop counters predicts every kept pair
// and checks it against the block. Directed tests cover color extremes,
// crop edges, size limits, resizing and backpressure; random frames cover the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import uyrc_pkg::*;

  localparam int unsigned MAX_PAIRS = 2048;
  localparam int unsigned MAX_LINES = 2048;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  uyrc_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  uyrc_out_t        out_data_o;

  uyvy_to_rgb555_crop #(
    .MAX_PAIRS_PER_ROW(MAX_PAIRS),
    .MAX_ROWS         (MAX_LINES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  logic [CFG_W-1:0] size_mirror [4];
  int               pair_col;
  int               line_row;
  bit               frame_done;
  uyrc_out_t        expected_pairs [$];

  bit tx_idle;
  bit rx_idle;
  int stall_left;
  int hold_left;
  int words_sent;
  int pairs_checked;
  int reg_writes;
  int frames_sent;
  int error_count;

  always #4 clk_i = ~clk_i;

  function automatic int eff_size(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) begin
      return 1;
    end
    return (v > limit) ? int'(limit) : int'(v);
  endfunction

  function automatic logic [4:0] chan5(int sum);
    int v;
    if (sum < 0) begin
      return 5'd0;
    end
    v = sum >>> 8;
    if (v > 255) begin
      v = 255;
    end
    return v[7:3];
  endfunction

  function automatic logic [15:0] rgb555(logic [7:0] luma, int d, int e);
    int c;
    c = (int'(luma) - 16) * 298 + 128;
    return {1'b1, chan5(c + 516 * d), chan5(c - 100 * d - 208 * e), chan5(c + 409 * e)};
  endfunction

  task automatic convert_and_crop(input uyrc_in_t w);
    int        sw, dw, sh, dh, kw, kh, d, e;
    uyrc_out_t px;
    sw = eff_size(size_mirror[REG_SRC_PAIRS], MAX_PAIRS);
    dw = eff_size(size_mirror[REG_DST_PAIRS], MAX_PAIRS);
    sh = eff_size(size_mirror[REG_SRC_ROWS], MAX_LINES);
    dh = eff_size(size_mirror[REG_DST_ROWS], MAX_LINES);
    kw = (sw < dw) ? sw : dw;
    kh = (sh < dh) ? sh : dh;
    d  = int'(w.chroma_u) - 128;
    e  = int'(w.chroma_v) - 128;
    if (w.frame_start) begin
      pair_col   = 0;
      line_row   = 0;
      frame_done = 1'b0;
    end
    if (!frame_done) begin
      if (pair_col < kw && line_row < kh) begin
        px.first_pixel  = rgb555(w.luma_first, d, e);
        px.second_pixel = rgb555(w.luma_second, d, e);
        px.row_end      = (pair_col == kw - 1);
        expected_pairs.push_back(px);
      end
      if (pair_col >= sw - 1) begin
        pair_col = 0;
        if (line_row >= sh - 1) begin
          frame_done = 1'b1;
        end else begin
          line_row++;
        end
      end else begin
        pair_col++;
      end
    end
  endtask

  task automatic push_word(input uyrc_in_t w);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    convert_and_crop(w);
    words_sent++;
    if (w.frame_start) begin
      frames_sent++;
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_size(input cfg_reg_e idx, input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    size_mirror[idx] = v;
    reg_writes++;
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] sp, input logic [CFG_W-1:0] dp,
                             input logic [CFG_W-1:0] sr, input logic [CFG_W-1:0] dr);
    write_size(REG_SRC_PAIRS, sp);
    write_size(REG_DST_PAIRS, dp);
    write_size(REG_SRC_ROWS, sr);
    write_size(REG_DST_ROWS, dr);
  endtask

  function automatic uyrc_in_t rand_word(logic fs);
    uyrc_in_t w;
    w.chroma_u    = 8'($urandom_range(0, 255));
    w.luma_first  = 8'($urandom_range(0, 255));
    w.chroma_v    = 8'($urandom_range(0, 255));
    w.luma_second = 8'($urandom_range(0, 255));
    w.frame_start = fs;
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(int unsigned small_max);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 12'd4095;
      2:       return 12'd2048;
      3:       return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(1, small_max));
    endcase
  endfunction

  always @(posedge clk_i) begin
    uyrc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pairs_checked++;
      if (expected_pairs.size() == 0) begin
        $error("unexpected output transfer: %h", out_data_o);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_data_o.first_pixel !== want.first_pixel) begin
          $error("first_pixel: expected %h, got %h", want.first_pixel, out_data_o.first_pixel);
          error_count++;
        end
        if (out_data_o.second_pixel !== want.second_pixel) begin
          $error("second_pixel: expected %h, got %h", want.second_pixel,
                 out_data_o.second_pixel);
          error_count++;
        end
        if (out_data_o.row_end !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, out_data_o.row_end);
          error_count++;
        end
      end
      stall_left = rx_idle ? $urandom_range(0, 12) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_color_extremes();
    push_word({8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
    push_word({8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    push_word({8'h80, 8'h10, 8'h80, 8'hEB, 1'b0});
    push_word({8'h80, 8'hEB, 8'h80, 8'h10, 1'b0});
    push_word({8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0});
    push_word({8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1});
    push_word({8'h00, 8'h80, 8'hFF, 8'h80, 1'b0});
    push_word({8'hFF, 8'h80, 8'h00, 8'h80, 1'b0});
    wait_for_results();
  endtask

  task automatic test_crop_edges();
    write_sizes(12'd3, 12'd2, 12'd2, 12'd1);
    for (int i = 0; i < 6; i++) begin
      push_word(rand_word(i == 0));
    end
    push_word(rand_word(1'b0));
    push_word(rand_word(1'b0));
    push_word(rand_word(1'b1));
    wait_for_results();
  endtask

  task automatic test_size_limits();
    write_sizes(12'd0, 12'd0, 12'd0, 12'd0);
    push_word(rand_word(1'b1));
    push_word(rand_word(1'b0));
    push_word(rand_word(1'b1));
    wait_for_results();
    write_sizes(12'd4095, 12'd1, 12'd4095, 12'd0);
    push_word(rand_word(1'b1));
    push_word(rand_word(1'b0));
    push_word(rand_word(1'b0));
    wait_for_results();
    write_sizes(12'd2048, 12'd4095, 12'd2048, 12'd4095);
    push_word(rand_word(1'b1));
    push_word(rand_word(1'b0));
    push_word(rand_word(1'b0));
    wait_for_results();
  endtask

  task automatic test_resize_mid_frame();
    write_sizes(12'd8, 12'd8, 12'd4, 12'd4);
    push_word(rand_word(1'b1));
    for (int i = 0; i < 4; i++) begin
      push_word(rand_word(1'b0));
    end
    wait_for_results();
    write_size(REG_SRC_PAIRS, 12'd3);
    for (int i = 0; i < 3; i++) begin
      push_word(rand_word(1'b0));
    end
    wait_for_results();
    write_size(REG_SRC_ROWS, 12'd1);
    for (int i = 0; i < 4; i++) begin
      push_word(rand_word(1'b0));
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    write_sizes(12'd16, 12'd16, 12'd16, 12'd16);
    tx_idle   = 1'b0;
    hold_left = 80;
    push_word(rand_word(1'b1));
    for (int i = 0; i < 39; i++) begin
      push_word(rand_word(1'b0));
    end
    wait_for_results();
    for (int i = 0; i < 10; i++) begin
      push_word(rand_word(1'b0));
    end
    wait_for_results();
  endtask

  task automatic test_random_frames();
    int sw, sh, len, frames;
    while (words_sent < 650) begin
      write_sizes(pick_size(6), pick_size(6), pick_size(4), pick_size(4));
      sw      = eff_size(size_mirror[REG_SRC_PAIRS], MAX_PAIRS);
      sh      = eff_size(size_mirror[REG_SRC_ROWS], MAX_LINES);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      frames  = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        len = (sw * sh <= 64) ? sw * sh : $urandom_range(8, 24);
        for (int i = 0; i < len; i++) begin
          push_word(rand_word(i == 0 || $urandom_range(0, 19) == 0));
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) push_word(rand_word(1'b0));
        end
      end
      wait_for_results();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SRC_PAIRS;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    stall_left    = 0;
    hold_left     = 0;
    words_sent    = 0;
    pairs_checked = 0;
    reg_writes    = 0;
    frames_sent   = 0;
    error_count   = 0;
    pair_col      = 0;
    line_row      = 0;
    frame_done    = 1'b0;
    size_mirror[REG_SRC_PAIRS] = SRC_PAIRS_RST;
    size_mirror[REG_DST_PAIRS] = DST_PAIRS_RST;
    size_mirror[REG_SRC_ROWS]  = SRC_ROWS_RST;
    size_mirror[REG_DST_ROWS]  = DST_ROWS_RST;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_color_extremes();
    test_crop_edges();
    test_size_limits();
    test_resize_mid_frame();
    test_backpressure();
    rx_idle = 1'b1;
    tx_idle = 1'b1;
    test_random_frames();
    wait_for_results();
    repeat (10) @(negedge clk_i);

    $display("Sent %0d words in %0d frame starts with %0d register writes.",
             words_sent, frames_sent, reg_writes);
    $display("Checked %0d pixel pairs, %0d mismatches.", pairs_checked, error_count);
    if (error_count == 0 && expected_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
